>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked and disabled by an active-low
// asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ITW_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define ITW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/itw_pkg.sv
// ----------------------------------------------------------------------------
// itw_pkg
// Types, constants and helper functions for the integer to word token block.
// ----------------------------------------------------------------------------
package itw_pkg;

	localparam int VALUE_W    = 31;
	localparam int CODE_W     = 5;
	localparam int BIN_W      = 32;
	localparam int BCD_DIGITS = 10;
	localparam int BCD_W      = 4 * BCD_DIGITS;
	localparam int STEP_BITS  = 4;
	localparam int CONV_STEPS = BIN_W / STEP_BITS;
	localparam int STEP_W     = $clog2(CONV_STEPS);

	// Four digit groups (billion, million, thousand, units), five word slots each:
	// hundreds digit, Hundred, teen/single/tens word, units word, scale word.
	localparam int NUM_GROUPS      = 4;
	localparam int SLOTS_PER_GROUP = 5;
	localparam int NUM_SLOTS       = NUM_GROUPS * SLOTS_PER_GROUP;

	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [CODE_W-1:0] CODE_ZERO     = 5'd0;
	localparam logic [CODE_W-1:0] CODE_TEN      = 5'd10;
	localparam logic [CODE_W-1:0] CODE_TENS_OFS = 5'd18;
	localparam logic [CODE_W-1:0] CODE_HUNDRED  = 5'd28;
	localparam logic [CODE_W-1:0] CODE_THOUSAND = 5'd29;
	localparam logic [CODE_W-1:0] CODE_MILLION  = 5'd30;
	localparam logic [CODE_W-1:0] CODE_BILLION  = 5'd31;

	typedef struct packed {
		logic [NUM_SLOTS-1:0][CODE_W-1:0] codes;
		logic [NUM_SLOTS-1:0]             mask;
	} entry_t;

	typedef struct packed {
		logic   push;
		entry_t entry;
	} qwr_t;

	typedef struct packed {
		logic   empty;
		entry_t entry;
	} qrd_t;

	// One double-dabble step: adjust each digit, then shift in one binary bit.
	function automatic logic [BCD_W-1:0] dabble_bit(input logic [BCD_W-1:0] bcd,
		input logic b);
		logic [BCD_W-1:0] adj;
		logic [3:0]       d;
		for (int i = 0; i < BCD_DIGITS; i++) begin
			d = bcd[4*i +: 4];
			adj[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
		end
		return {adj[BCD_W-2:0], b};
	endfunction

	function automatic logic [CODE_W-1:0] scale_code(input int g);
		case (g)
			0:       return CODE_BILLION;
			1:       return CODE_MILLION;
			default: return CODE_THOUSAND;
		endcase
	endfunction

	// Turn ten decimal digits into a slot list: a code and an enable per slot.
	function automatic entry_t classify(input logic [BCD_W-1:0] bcd);
		entry_t      e;
		logic [47:0] bx;
		logic [3:0]  h;
		logic [3:0]  t;
		logic [3:0]  u;
		logic        gnz;
		int          b;
		bx = {8'd0, bcd};
		for (int g = 0; g < NUM_GROUPS; g++) begin
			h   = bx[(11 - 3*g)*4 +: 4];
			t   = bx[(10 - 3*g)*4 +: 4];
			u   = bx[(9 - 3*g)*4 +: 4];
			gnz = (h != 4'd0) || (t != 4'd0) || (u != 4'd0);
			b   = g * SLOTS_PER_GROUP;
			e.codes[b]     = {1'b0, h};
			e.mask[b]      = (h != 4'd0);
			e.codes[b + 1] = CODE_HUNDRED;
			e.mask[b + 1]  = (h != 4'd0);
			if (t >= 4'd2) begin
				e.codes[b + 2] = CODE_TENS_OFS + {1'b0, t};
				e.mask[b + 2]  = 1'b1;
			end else begin
				e.codes[b + 2] = t[0] ? CODE_TEN + {1'b0, u} : {1'b0, u};
				e.mask[b + 2]  = t[0] || (u != 4'd0);
			end
			e.codes[b + 3] = {1'b0, u};
			e.mask[b + 3]  = (t >= 4'd2) && (u != 4'd0);
			e.codes[b + 4] = scale_code(g);
			e.mask[b + 4]  = gnz && (g < NUM_GROUPS - 1);
		end
		// Zero alone spells Zero, in the teen/single/tens word slot of the units group.
		if (bcd == '0) begin
			e.codes[NUM_SLOTS - 3] = CODE_ZERO;
			e.mask[NUM_SLOTS - 3]  = 1'b1;
		end
		return e;
	endfunction

endpackage

>>> hdl/itw_front.sv
// ----------------------------------------------------------------------------
// itw_front
// Input buffer, binary to decimal converter (four bits per cycle) and word
// slot classification; hands one slot list per number to the queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module itw_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [itw_pkg::VALUE_W-1:0]   value,
	output itw_pkg::qwr_t                 wr,
	input  logic                          q_full
);

	logic                          buf_valid_q;
	logic [itw_pkg::VALUE_W-1:0]   buf_value_q;
	logic                          busy_q;
	logic                          hold_q;
	logic [itw_pkg::STEP_W-1:0]    step_q;
	logic [itw_pkg::BIN_W-1:0]     bin_q;
	logic [itw_pkg::BCD_W-1:0]     bcd_q;
	logic [itw_pkg::BCD_W-1:0]     bcd_next;
	logic                          accept;
	logic                          push_ok;
	logic                          start;
	logic                          last_step;

	assign full      = buf_valid_q;
	assign accept    = push & ~buf_valid_q;
	assign push_ok   = hold_q & ~q_full;
	assign start     = buf_valid_q & ~busy_q & (~hold_q | push_ok);
	assign last_step = busy_q & (step_q == itw_pkg::STEP_W'(itw_pkg::CONV_STEPS - 1));

	always_comb begin
		bcd_next = bcd_q;
		for (int k = 0; k < itw_pkg::STEP_BITS; k++) begin
			bcd_next = itw_pkg::dabble_bit(bcd_next, bin_q[itw_pkg::BIN_W-1-k]);
		end
	end

	assign wr.push  = hold_q;
	assign wr.entry = itw_pkg::classify(bcd_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_valid_q <= 1'b0;
			busy_q      <= 1'b0;
			hold_q      <= 1'b0;
			step_q      <= '0;
		end else begin
			if (accept) begin
				buf_valid_q <= 1'b1;
			end else if (start) begin
				buf_valid_q <= 1'b0;
			end
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
			// hold the finished digits until the queue takes them
			if (last_step) begin
				hold_q <= 1'b1;
			end else if (push_ok) begin
				hold_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			buf_value_q <= value;
		end
		if (start) begin
			bin_q <= {1'b0, buf_value_q};
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= bin_q << itw_pkg::STEP_BITS;
			bcd_q <= bcd_next;
		end
	end

	`ITW_ASSERT(a_busy_hold_excl, clk, arst_n, !(busy_q && hold_q), "converter busy while holding a result")
	`ITW_ASSERT_NEXT(a_done_holds, clk, arst_n, last_step, hold_q && !busy_q, "finished conversion not held")
	`ITW_ASSERT_NEXT(a_start_busy, clk, arst_n, start, busy_q && step_q == '0, "start did not launch converter")

endmodule

>>> hdl/itw_queue.sv
// ----------------------------------------------------------------------------
// itw_queue
// Short first-in first-out queue of slot lists between front and back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module itw_queue #(
	parameter int DEPTH = itw_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  itw_pkg::qwr_t  wr,
	output logic           q_full,
	output itw_pkg::qrd_t  rd,
	input  logic           rd_pop
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	itw_pkg::entry_t  mem_q [DEPTH];
	logic [IW-1:0]    wr_ptr_q;
	logic [IW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign q_full   = (count_q == CW'(DEPTH));
	assign rd.empty = (count_q == '0);
	assign rd.entry = mem_q[rd_ptr_q];
	assign do_wr    = wr.push & ~q_full;
	assign do_rd    = rd_pop & ~rd.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == IW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == IW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr.entry;
		end
	end

	`ITW_ASSERT(a_count_range, clk, arst_n, count_q <= CW'(DEPTH), "queue count beyond depth")
	`ITW_ASSERT_NEXT(a_full_drop, clk, arst_n, q_full && !do_rd, q_full, "full queue lost an entry")

endmodule

>>> hdl/itw_back.sv
// ----------------------------------------------------------------------------
// itw_back
// Word sequencer: walks the enabled slots of one slot list, one word per
// cycle while pop keeps the output free, into the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module itw_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  itw_pkg::qrd_t                rd,
	output logic                         rd_pop,
	output logic                         empty,
	input  logic                         pop,
	output logic [itw_pkg::CODE_W-1:0]   word_code,
	output logic                         last_word
);

	logic [itw_pkg::NUM_SLOTS-1:0][itw_pkg::CODE_W-1:0] codes_q;
	logic [itw_pkg::NUM_SLOTS-1:0]                      mask_q;
	logic [itw_pkg::NUM_SLOTS-1:0]                      sel;
	logic [itw_pkg::NUM_SLOTS-1:0]                      rest;
	logic [itw_pkg::CODE_W-1:0]                         code_sel;
	logic                                               out_valid_q;
	logic [itw_pkg::CODE_W-1:0]                         out_code_q;
	logic                                               out_last_q;
	logic                                               adv;
	logic                                               emit;
	logic                                               load;

	// lowest enabled slot goes first
	assign sel  = mask_q & (~mask_q + 1'b1);
	assign rest = mask_q & ~sel;

	always_comb begin
		code_sel = '0;
		for (int i = 0; i < itw_pkg::NUM_SLOTS; i++) begin
			code_sel = code_sel | (codes_q[i] & {itw_pkg::CODE_W{sel[i]}});
		end
	end

	assign adv    = ~out_valid_q | pop;
	assign emit   = adv & (mask_q != '0);
	assign load   = ~rd.empty & ((mask_q == '0) | (emit & (rest == '0)));
	assign rd_pop = load;

	assign empty     = ~out_valid_q;
	assign word_code = out_code_q;
	assign last_word = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				mask_q <= rd.entry.mask;
			end else if (emit) begin
				mask_q <= rest;
			end
			if (adv) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			codes_q <= rd.entry.codes;
		end
		if (emit) begin
			out_code_q <= code_sel;
			out_last_q <= (rest == '0);
		end
	end

	`ITW_ASSERT_NEXT(a_last_on_final, clk, arst_n, emit && rest == '0, out_valid_q && out_last_q, "final word not marked last")
	`ITW_ASSERT_NEXT(a_not_last_early, clk, arst_n, emit && rest != '0, out_valid_q && !out_last_q, "word marked last too early")
	`ITW_ASSERT(a_load_safe, clk, arst_n, !(load && emit && rest != '0), "slot list replaced mid-number")

endmodule

>>> hdl/integer_to_word_tokens.sv
// ----------------------------------------------------------------------------
// integer_to_word_tokens
// Spells a 31-bit unsigned integer as a run of English word codes.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive value and raise push; the beat is taken on a clock edge
//   with push high and full low. A one-entry buffer takes the next number while
//   the previous one is still being converted.
//   Result queue: while empty is low, word_code/last_word show the oldest word;
//   pop high with empty low takes it. last_word marks the final word of a number.
// Path: an accepted beat passes the input buffer, the converter (four bits per
//   cycle), then the queue and sequencer stages before its first word shows.
// Throughput: the converter works on one number at a time; the sequencer emits
//   one word per cycle while pop keeps up, 1 to 16 words per number.
// Stall: when pop stays low the output word holds, the sequencer and the slot
//   queue fill, then full rises. Nothing is dropped.
// Reset: arst_n clears all buffers and queues; no items are in flight after it.
// ----------------------------------------------------------------------------
module integer_to_word_tokens #(
	parameter int QUEUE_DEPTH = itw_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [itw_pkg::VALUE_W-1:0]  value,
	output logic                         empty,
	input  logic                         pop,
	output logic [itw_pkg::CODE_W-1:0]   word_code,
	output logic                         last_word
);

	itw_pkg::qwr_t  wr;
	itw_pkg::qrd_t  rd;
	logic           q_full;
	logic           rd_pop;

	itw_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.value  (value),
		.wr     (wr),
		.q_full (q_full)
	);

	itw_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.q_full (q_full),
		.rd     (rd),
		.rd_pop (rd_pop)
	);

	itw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd        (rd),
		.rd_pop    (rd_pop),
		.empty     (empty),
		.pop       (pop),
		.word_code (word_code),
		.last_word (last_word)
	);

endmodule

>>> verif/spelling_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spelling_checker
// Watches both queue ports of the word token block. Each accepted number is
// spelled here into the words it should give; each accepted word is compared
// with the oldest one still owed. Mismatches and stray words are counted.
// ----------------------------------------------------------------------------
module spelling_checker import itw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  logic [VALUE_W-1:0] value,
	input  logic               empty,
	input  logic               pop,
	input  logic [CODE_W-1:0]  word_code,
	input  logic               last_word,
	output int                 fail_count,
	output int                 pending
);

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              last;
	} word_t;

	word_t owed_words[$];
	word_t want;

	initial fail_count = 0;
	assign pending = owed_words.size();

	function automatic void add_word(input logic [CODE_W-1:0] code);
		owed_words.insert(owed_words.size(), word_t'{code, 1'b0});
	endfunction

	// Spell one group 0..999: hundreds digit and Hundred, then the part below 100.
	function automatic void spell_group(input int unsigned grp);
		int unsigned hundreds;
		int unsigned rest;
		hundreds = grp / 100;
		rest     = grp % 100;
		if (hundreds != 0) begin
			add_word(CODE_W'(hundreds));
			add_word(CODE_HUNDRED);
		end
		if (rest == 0)
			return;
		if (rest < 20) begin
			add_word(CODE_W'(rest));
		end else begin
			add_word(CODE_TENS_OFS + CODE_W'(rest / 10));
			if (rest % 10 != 0)
				add_word(CODE_W'(rest % 10));
		end
	endfunction

	function automatic void spell_value(input logic [VALUE_W-1:0] v);
		int unsigned num;
		num = v;
		if (num == 0) begin
			owed_words.insert(owed_words.size(), word_t'{CODE_ZERO, 1'b1});
			return;
		end
		// Zero groups give neither words nor a scale word.
		if (num >= 32'd1000000000) begin
			spell_group(num / 32'd1000000000);
			add_word(CODE_BILLION);
			num = num % 32'd1000000000;
		end
		if (num >= 32'd1000000) begin
			spell_group(num / 32'd1000000);
			add_word(CODE_MILLION);
			num = num % 32'd1000000;
		end
		if (num >= 32'd1000) begin
			spell_group(num / 32'd1000);
			add_word(CODE_THOUSAND);
			num = num % 32'd1000;
		end
		spell_group(num);
		owed_words[$].last = 1'b1;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				spell_value(value);
			if (pop && !empty) begin
				if (owed_words.size() == 0) begin
					$error("word beat with nothing owed: word_code %0d last_word %0b",
						word_code, last_word);
					fail_count++;
				end else begin
					want = owed_words.pop_front();
					if (word_code !== want.code) begin
						$error("word_code: expected %0d, got %0d", want.code, word_code);
						fail_count++;
					end
					if (last_word !== want.last) begin
						$error("last_word: expected %0b, got %0b", want.last, last_word);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds numbers into the word token block, chosen edge cases first, then random
// numbers, most built group by group, under random gaps on both, one or no
// queue side. A separate checker predicts and compares every word beat.
// ----------------------------------------------------------------------------
module testbench;
	import itw_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 30;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               pop = 1'b0;
	logic [VALUE_W-1:0] value = '0;
	logic               full;
	logic               empty;
	logic [CODE_W-1:0]  word_code;
	logic               last_word;
	int                 fail_count;
	int                 pending;
	int                 in_gap_max = 10;
	int                 out_gap_max = 10;
	int                 stall_cycles = 0;

	int unsigned directed_values[$] = '{
		0, 1, 7, 10, 13, 19, 20, 45, 90, 99, 100, 101, 115, 340, 999, 1000, 1001,
		12345, 100000, 1000000, 1000010, 999999999, 1000000000, 2000000001,
		2147483647
	};

	always #2 clk = ~clk;

	integer_to_word_tokens uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.value     (value),
		.empty     (empty),
		.pop       (pop),
		.word_code (word_code),
		.last_word (last_word)
	);

	spelling_checker monitor (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.value      (value),
		.empty      (empty),
		.pop        (pop),
		.word_code  (word_code),
		.last_word  (last_word),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Favor groups that hit the teen, exact-ten and bare-hundred spellings.
	function automatic int unsigned random_group();
		case ($urandom_range(0, 5))
			0:       return 0;
			1:       return $urandom_range(1, 19);
			2:       return 10 * $urandom_range(2, 9);
			3:       return 100 * $urandom_range(1, 9);
			default: return $urandom_range(0, 999);
		endcase
	endfunction

	// Hold push high into the next beat when no gap is drawn.
	task automatic send_number(input logic [VALUE_W-1:0] v);
		int gap;
		gap = $urandom_range(0, in_gap_max);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push  <= 1'b1;
		value <= v;
		do @(posedge clk); while (full);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(0, out_gap_max);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	initial begin
		longint unsigned n;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_values[i])
			send_number(VALUE_W'(directed_values[i]));

		for (int seg = 0; seg < 4; seg++) begin
			case (seg)
				0: begin in_gap_max = 10; out_gap_max = 10; end
				1: begin in_gap_max = 0;  out_gap_max = 0;  end
				2: begin in_gap_max = 0;  out_gap_max = 10; end
				default: begin in_gap_max = 10; out_gap_max = 0; end
			endcase
			repeat (40) begin
				case ($urandom_range(0, 7))
					0, 1: n = $urandom & 32'h7fffffff;
					2:    n = $urandom_range(0, 999);
					default: begin
						n = 64'd1000000000 * $urandom_range(0, 2)
							+ 64'd1000000 * random_group()
							+ 64'd1000 * random_group()
							+ random_group();
						if (n > 64'd2147483647)
							n = n - 64'd1000000000;
					end
				endcase
				send_number(VALUE_W'(n));
			end
		end
		push <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> files.f
+incdir+hdl
hdl/itw_pkg.sv
hdl/itw_front.sv
hdl/itw_queue.sv
hdl/itw_back.sv
hdl/integer_to_word_tokens.sv
verif/spelling_checker.sv
verif/testbench.sv
